// ===== hdl/dependency_priority_dispatcher_assert.svh =====
`ifndef DEPENDENCY_PRIORITY_DISPATCHER_ASSERT_SVH
`define DEPENDENCY_PRIORITY_DISPATCHER_ASSERT_SVH

// clocked assertion with reset gating, reports by error
`define DPD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same, taken through the clocked form
`define DPD_ASSERT(lbl, prop, msg) `DPD_ASSERT_CLK(lbl, prop, msg)

`endif

// ===== hdl/dpd_pkg.sv =====
package dpd_pkg;

  localparam int unsigned MaskBits = 32;
  localparam int unsigned BudgetBits = 6;
  localparam int unsigned TickBits = 32;
  localparam int unsigned IdBits = 6;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned InPrioBits = 8;

  localparam logic [BudgetBits-1:0] BudgetLimit = 6'd32;

  localparam logic [StatusBits-1:0] StatusOk = 2'd0;
  localparam logic [StatusBits-1:0] StatusUnknownDep = 2'd1;
  localparam logic [StatusBits-1:0] StatusTableFull = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StSched,
    StRun,
    StScan,
    StScanEnd,
    StCommit,
    StDispatch
  } state_e;

  typedef struct packed {
    logic latch;
    logic sched;
    logic load_empty;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic dispatch;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic run_empty;
    logic scan_last;
    logic more;
  } sts_t;

endpackage

// ===== hdl/dpd_ctrl.sv =====
module dpd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          mode_i,
  output logic          in_ready_o,
  input  dpd_pkg::sts_t sts_i,
  output dpd_pkg::cmd_t cmd_o
);

  dpd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpd_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = mode_i ? dpd_pkg::StRun : dpd_pkg::StSched;
        end
      end
      dpd_pkg::StSched: begin
        if (sts_i.out_free) state_d = dpd_pkg::StIdle;
      end
      dpd_pkg::StRun: begin
        if (!sts_i.run_empty) begin
          state_d = dpd_pkg::StScan;
        end else if (sts_i.out_free) begin
          state_d = dpd_pkg::StIdle;
        end
      end
      dpd_pkg::StScan: begin
        if (sts_i.scan_last) state_d = dpd_pkg::StScanEnd;
      end
      dpd_pkg::StScanEnd: state_d = dpd_pkg::StCommit;
      dpd_pkg::StCommit: state_d = dpd_pkg::StDispatch;
      dpd_pkg::StDispatch: begin
        if (sts_i.out_free) begin
          state_d = sts_i.more ? dpd_pkg::StScan : dpd_pkg::StIdle;
        end
      end
      default: state_d = dpd_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dpd_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      dpd_pkg::StSched: cmd_o.sched = sts_i.out_free;
      dpd_pkg::StRun: begin
        cmd_o.scan_start = !sts_i.run_empty;
        cmd_o.load_empty = sts_i.run_empty && sts_i.out_free;
      end
      dpd_pkg::StScan: cmd_o.scan_step = 1'b1;
      dpd_pkg::StScanEnd: cmd_o = '0;
      dpd_pkg::StCommit: cmd_o.commit = 1'b1;
      dpd_pkg::StDispatch: begin
        cmd_o.dispatch = sts_i.out_free;
        cmd_o.scan_start = sts_i.out_free && sts_i.more;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hdl/dpd_datapath.sv =====
module dpd_datapath #(
  parameter int unsigned MAX_JOBS = 32,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dpd_pkg::cmd_t                       cmd_i,
  output dpd_pkg::sts_t                       sts_o,
  input  logic [dpd_pkg::InPrioBits-1:0]      job_priority_i,
  input  logic [dpd_pkg::MaskBits-1:0]        dependency_mask_i,
  input  logic [dpd_pkg::BudgetBits-1:0]      run_budget_i,
  input  logic [dpd_pkg::TickBits-1:0]        tick_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dpd_pkg::IdBits-1:0]          job_id_o,
  output logic [dpd_pkg::StatusBits-1:0]      status_o,
  output logic [dpd_pkg::TickBits-1:0]        tick_echo_o,
  output logic [dpd_pkg::IdBits-1:0]          pending_count_o,
  output logic                                last_o
);

  localparam int unsigned IW = $clog2(MAX_JOBS);
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned MB = dpd_pkg::MaskBits;
  localparam int unsigned OB = dpd_pkg::IdBits;

  // latched input beat
  logic [PRIORITY_BITS-1:0]          prio_q;
  logic [MB-1:0]                     mask_q;
  logic [dpd_pkg::BudgetBits-1:0]    budget_q;
  logic [dpd_pkg::TickBits-1:0]      tick_q;

  // job state
  logic [CW-1:0]        issued_q;
  logic [CW-1:0]        pending_q;
  logic [MAX_JOBS-1:0]  completed_q;
  logic [MB-1:0]        dep_q [MAX_JOBS];
  logic [PRIORITY_BITS-1:0] prio_mem [MAX_JOBS];

  // scan
  logic [IW-1:0]            scan_q;
  logic [IW-1:0]            rd_idx_q;
  logic                     rd_rdy_q;
  logic                     rd_v_q;
  logic [PRIORITY_BITS-1:0] rd_prio_q;
  logic                     found_q;
  logic [IW-1:0]            best_idx_q;
  logic [PRIORITY_BITS-1:0] best_prio_q;
  logic [dpd_pkg::BudgetBits-1:0] cnt_q;

  // output register
  logic                           out_valid_q;
  logic [OB-1:0]                  id_q;
  logic [dpd_pkg::StatusBits-1:0] status_q;
  logic [dpd_pkg::TickBits-1:0]   tick_echo_q;
  logic [OB-1:0]                  pend_out_q;
  logic                           last_q;

  logic [MB-1:0]       comp32;
  logic [MB-1:0]       known;
  logic [MAX_JOBS-1:0] rdy;
  logic                unknown_dep;
  logic                full;
  logic                any_rdy;

  logic [PRIORITY_BITS+dpd_pkg::InPrioBits-1:0] prio_wide;
  logic [IW:0]         new_id;
  logic [IW+OB:0]      new_id_wide;
  logic [IW:0]         best_id;
  logic [IW+OB:0]      best_id_wide;
  logic [CW-1:0]       pend_inc;
  logic [CW-1:0]       pend_dec;
  logic [CW+OB-1:0]    pend_inc_wide;
  logic [CW+OB-1:0]    pend_cur_wide;

  always_comb begin
    comp32 = '0;
    known = '0;
    for (int b = 0; b < MB; b++) begin
      if (b < MAX_JOBS) begin
        comp32[b] = completed_q[b];
        known[b] = CW'(b) < issued_q;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_JOBS; j++) begin
      rdy[j] = (CW'(j) < issued_q) && !completed_q[j] && ((dep_q[j] & ~comp32) == '0);
    end
  end

  assign any_rdy     = |rdy;
  assign unknown_dep = |(mask_q & ~known);
  assign full        = issued_q == CW'(MAX_JOBS);

  assign prio_wide     = {{PRIORITY_BITS{1'b0}}, job_priority_i};
  assign new_id        = (IW+1)'(issued_q[IW-1:0]) + 1'b1;
  assign new_id_wide   = {{OB{1'b0}}, new_id};
  assign best_id       = (IW+1)'(best_idx_q) + 1'b1;
  assign best_id_wide  = {{OB{1'b0}}, best_id};
  assign pend_inc      = pending_q + 1'b1;
  assign pend_dec      = pending_q - 1'b1;
  assign pend_inc_wide = {{OB{1'b0}}, pend_inc};
  assign pend_cur_wide = {{OB{1'b0}}, pending_q};

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.run_empty = (budget_q == '0) || !any_rdy;
  assign sts_o.scan_last = scan_q == IW'(MAX_JOBS - 1);
  assign sts_o.more      = (cnt_q < budget_q) && any_rdy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      prio_q   <= prio_wide[PRIORITY_BITS-1:0];
      mask_q   <= dependency_mask_i;
      budget_q <= (run_budget_i > dpd_pkg::BudgetLimit) ? dpd_pkg::BudgetLimit : run_budget_i;
      tick_q   <= tick_value_i;
    end
    if (cmd_i.sched && !unknown_dep && !full) begin
      prio_mem[issued_q[IW-1:0]] <= prio_q;
      dep_q[issued_q[IW-1:0]]    <= mask_q;
    end
    rd_prio_q <= prio_mem[scan_q];
    rd_idx_q  <= scan_q;
    rd_rdy_q  <= rdy[scan_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issued_q    <= '0;
      pending_q   <= '0;
      completed_q <= '0;
      scan_q      <= '0;
      rd_v_q      <= 1'b0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_prio_q <= '0;
      cnt_q       <= '0;
    end else begin
      rd_v_q <= cmd_i.scan_step;
      if (cmd_i.latch) cnt_q <= '0;
      if (cmd_i.sched && !unknown_dep && !full) begin
        issued_q  <= issued_q + 1'b1;
        pending_q <= pend_inc;
      end
      if (cmd_i.scan_step) scan_q <= scan_q + 1'b1;
      if (rd_v_q && rd_rdy_q && (!found_q || rd_prio_q > best_prio_q)) begin
        found_q     <= 1'b1;
        best_idx_q  <= rd_idx_q;
        best_prio_q <= rd_prio_q;
      end
      if (cmd_i.commit) begin
        completed_q[best_idx_q] <= 1'b1;
        pending_q <= pend_dec;
        cnt_q     <= cnt_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.sched || cmd_i.load_empty || cmd_i.dispatch) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sched) begin
      tick_echo_q <= '0;
      last_q      <= 1'b1;
      if (unknown_dep) begin
        id_q       <= '0;
        status_q   <= dpd_pkg::StatusUnknownDep;
        pend_out_q <= pend_cur_wide[OB-1:0];
      end else if (full) begin
        id_q       <= '0;
        status_q   <= dpd_pkg::StatusTableFull;
        pend_out_q <= pend_cur_wide[OB-1:0];
      end else begin
        id_q       <= new_id_wide[OB-1:0];
        status_q   <= dpd_pkg::StatusOk;
        pend_out_q <= pend_inc_wide[OB-1:0];
      end
    end else if (cmd_i.load_empty) begin
      id_q        <= '0;
      status_q    <= dpd_pkg::StatusOk;
      tick_echo_q <= '0;
      pend_out_q  <= pend_cur_wide[OB-1:0];
      last_q      <= 1'b1;
    end else if (cmd_i.dispatch) begin
      id_q        <= best_id_wide[OB-1:0];
      status_q    <= dpd_pkg::StatusOk;
      tick_echo_q <= tick_q;
      pend_out_q  <= pend_cur_wide[OB-1:0];
      last_q      <= !sts_o.more;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign job_id_o        = id_q;
  assign status_o        = status_q;
  assign tick_echo_o     = tick_echo_q;
  assign pending_count_o = pend_out_q;
  assign last_o          = last_q;

endmodule

// ===== hdl/dependency_priority_dispatcher.sv =====
// dependency priority dispatcher
// input channel (in_valid_i/in_ready_o): mode_i 0 schedules a job with
// job_priority_i and dependency_mask_i, mode_i 1 runs up to run_budget_i
// (capped at 32) ready jobs, tagging each with tick_value_i
// output channel (out_valid_o/out_ready_i): one beat per schedule item,
// one beat per dispatched job of a run item or one empty beat, last_o
// marks the final beat of an item
// a schedule beat is loaded from the latched input beat once the output
// register is free; in each dispatch the ready jobs are found by reading
// the priority memory one entry per cycle, then the winner is retired and
// its beat is loaded; a run item first checks for ready jobs and budget
// one item is in flight at a time; in_ready_o is high only between items
// a stalled receiver holds the output register and the sequencer waits
// in front of it; the next input is still taken while the last beat waits
// reset empties the job table (no ids issued, nothing pending) and
// drops any waiting output beat
module dependency_priority_dispatcher #(
  parameter int unsigned MAX_JOBS = 32,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  job_priority_i,
  input  logic [31:0] dependency_mask_i,
  input  logic [5:0]  run_budget_i,
  input  logic [31:0] tick_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  job_id_o,
  output logic [1:0]  status_o,
  output logic [31:0] tick_echo_o,
  output logic [5:0]  pending_count_o,
  output logic        last_o
);

  dpd_pkg::cmd_t cmd;
  dpd_pkg::sts_t sts;

  dpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dpd_datapath #(
    .MAX_JOBS      (MAX_JOBS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .job_priority_i    (job_priority_i),
    .dependency_mask_i (dependency_mask_i),
    .run_budget_i      (run_budget_i),
    .tick_value_i      (tick_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .job_id_o          (job_id_o),
    .status_o          (status_o),
    .tick_echo_o       (tick_echo_o),
    .pending_count_o   (pending_count_o),
    .last_o            (last_o)
  );

endmodule

// ===== hdl/dpd_checker.sv =====
`include "dependency_priority_dispatcher_assert.svh"

module dpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  job_id_o,
  input logic [1:0]  status_o,
  input logic [31:0] tick_echo_o,
  input logic        last_o
);

  // waiting beat is held
  `DPD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(job_id_o), "output beat dropped")

  `DPD_ASSERT(a_status_code, out_valid_o |-> status_o <= dpd_pkg::StatusTableFull, "status code out of range")

  // a rejected schedule carries no id and ends its item
  `DPD_ASSERT(a_reject_shape, out_valid_o && status_o != dpd_pkg::StatusOk |-> job_id_o == 6'd0 && last_o, "bad reject beat")

  // a tick is only echoed for a dispatched job
  `DPD_ASSERT(a_tick_needs_id, out_valid_o && tick_echo_o != 32'd0 |-> job_id_o != 6'd0 && status_o == dpd_pkg::StatusOk, "tick without job")

endmodule

bind dependency_priority_dispatcher dpd_checker u_dpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .job_id_o    (job_id_o),
  .status_o    (status_o),
  .tick_echo_o (tick_echo_o),
  .last_o      (last_o)
);
